// ===== rtl/core/psgp_pkg.sv =====
// shared types, register indexes and helpers for the positional gain and pan block
package psgp_pkg;

  localparam int unsigned ChannelCountDefault = 16;
  localparam int unsigned CoordBitsDefault    = 21;
  localparam int unsigned CfgIndexBits        = 3;
  localparam logic [63:0] VolLowReset         = 64'd255;
  localparam logic [15:0] RadiusReset         = 16'd1500;

  // configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    REG_VOL_LOW    = 3'd0,
    REG_VOL_HIGH   = 3'd1,
    REG_PAN_ENABLE = 3'd2,
    REG_LISTENER_X = 3'd3,
    REG_LISTENER_Y = 3'd4,
    REG_RADIUS     = 3'd5
  } cfg_reg_t;

  // sideband that travels beside the square root
  typedef struct packed {
    logic [8:0]  sample;
    logic [7:0]  vol;
    logic        active;
    logic        audible;
    logic        no_pan;
    logic        dx_pos;
    logic [15:0] ax;
    logic [15:0] radius;
  } side_t;

  // sideband beside the far-side divider
  typedef struct packed {
    side_t       side;
    logic [15:0] distance;
  } mid_t;

  // sideband beside the final dividers
  typedef struct packed {
    logic [8:0] sample;
    logic [7:0] vol;
    logic       active;
  } tail_t;

  // floor(y / 255) for y below 65280
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [16:0] t;
    t = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== rtl/core/psgp_ifs.sv =====
// word channel interfaces for requests, results and register writes
interface psgp_in_if #(
  parameter int unsigned COORD_BITS = psgp_pkg::CoordBitsDefault
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   channel_index;
  logic [8:0]                   sample_index;
  logic                         positional;
  logic                         no_panning;
  logic signed [COORD_BITS-1:0] source_x;
  logic signed [COORD_BITS-1:0] source_y;

  modport source(output valid, channel_index, sample_index, positional, no_panning,
                 source_x, source_y, input ready);
  modport sink(input valid, channel_index, sample_index, positional, no_panning,
               source_x, source_y, output ready);
endinterface

interface psgp_out_if;
  logic              valid;
  logic              ready;
  logic              start_playback;
  logic [8:0]        sample_out;
  logic [6:0]        volume_percent;
  logic signed [7:0] pan_percent;

  modport source(output valid, start_playback, sample_out, volume_percent, pan_percent,
                 input ready);
  modport sink(input valid, start_playback, sample_out, volume_percent, pan_percent,
               output ready);
endinterface

interface psgp_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [psgp_pkg::CfgIndexBits-1:0]     index;
  logic [63:0]                           data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/psgp_front.sv =====
// front stages: channel lookup, offsets, squares and audibility test
module psgp_front #(
  parameter int unsigned CHANNEL_COUNT = psgp_pkg::ChannelCountDefault,
  parameter int unsigned COORD_BITS    = psgp_pkg::CoordBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [3:0]                   channel_index,
  input  logic [8:0]                   sample_index,
  input  logic                         positional,
  input  logic                         no_panning,
  input  logic signed [COORD_BITS-1:0] source_x,
  input  logic signed [COORD_BITS-1:0] source_y,
  input  logic [127:0]                 vol_all,
  input  logic [15:0]                  pan_enable,
  input  logic signed [COORD_BITS-1:0] listener_x,
  input  logic signed [COORD_BITS-1:0] listener_y,
  input  logic [15:0]                  radius,
  output logic                         out_valid,
  output logic [31:0]                  out_sq,
  output psgp_pkg::side_t              out_side
);
  localparam int unsigned D_W  = COORD_BITS + 1;
  localparam int unsigned SQ_W = 2 * D_W;
  localparam int unsigned S_W  = SQ_W + 1;

  // stage 1: lookup and absolute offsets
  logic                  v1_r;
  logic [D_W-1:0]        ax1_r, ay1_r;
  psgp_pkg::side_t       sd1_r;
  logic signed [D_W-1:0] dx, dy;
  logic [D_W-1:0]        ax, ay;
  logic                  ch_ok;
  psgp_pkg::side_t       sd1_nxt;

  always_comb begin
    dx = D_W'(source_x) - D_W'(listener_x);
    dy = D_W'(source_y) - D_W'(listener_y);
    ax = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ay = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    ch_ok = ({1'b0, channel_index} < 5'(CHANNEL_COUNT));
    sd1_nxt.sample  = sample_index;
    sd1_nxt.vol     = ch_ok ? vol_all[channel_index*8 +: 8] : 8'd0;
    sd1_nxt.active  = ch_ok && positional && pan_enable[channel_index];
    sd1_nxt.audible = 1'b0;
    sd1_nxt.no_pan  = no_panning;
    sd1_nxt.dx_pos  = !dx[D_W-1] && (dx != '0);
    sd1_nxt.ax      = 16'd0;
    sd1_nxt.radius  = radius;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      ax1_r <= ax;
      ay1_r <= ay;
      sd1_r <= sd1_nxt;
    end
  end

  // stage 2: squares
  logic            v2_r;
  logic [SQ_W-1:0] ax2_r, ay2_r;
  logic [31:0]     rr2_r;
  logic [D_W-1:0]  axk2_r;
  psgp_pkg::side_t sd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      ax2_r  <= SQ_W'(ax1_r) * SQ_W'(ax1_r);
      ay2_r  <= SQ_W'(ay1_r) * SQ_W'(ay1_r);
      rr2_r  <= 32'(sd1_r.radius) * 32'(sd1_r.radius);
      axk2_r <= ax1_r;
      sd2_r  <= sd1_r;
    end
  end

  // stage 3: sum and compare against radius squared
  logic               v3_r;
  logic [31:0]        sq3_r;
  psgp_pkg::side_t    sd3_r;
  logic [S_W-1:0]     s;
  logic [S_W+31:0]    s_ext, rr_ext;
  logic [D_W+15:0]    ax_ext;
  psgp_pkg::side_t    sd3_nxt;

  always_comb begin
    s      = S_W'(ax2_r) + S_W'(ay2_r);
    s_ext  = {32'd0, s};
    rr_ext = {{S_W{1'b0}}, rr2_r};
    ax_ext = {16'd0, axk2_r};
    sd3_nxt         = sd2_r;
    sd3_nxt.audible = sd2_r.active && (sd2_r.radius != 16'd0) && (s_ext < rr_ext);
    sd3_nxt.ax      = ax_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      sq3_r <= s_ext[31:0];
      sd3_r <= sd3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_sq    = sq3_r;
  assign out_side  = sd3_r;

endmodule

// ===== rtl/core/psgp_sqrt.sv =====
// sixteen-stage integer square root, one root bit per stage
module psgp_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [15:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int unsigned Steps = 16;

  logic              v_r    [Steps];
  logic [17:0]       rem_r  [Steps];
  logic [15:0]       root_r [Steps];
  logic [31:0]       sh_r   [Steps];
  logic [SIDE_W-1:0] side_r [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic              v_i;
    logic [17:0]       rem_i;
    logic [15:0]       root_i;
    logic [31:0]       sh_i;
    logic [SIDE_W-1:0] side_i;
    logic [19:0]       tmp, trial;
    logic [17:0]       rem_n;
    logic [15:0]       root_n;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = 18'd0;
      assign root_i = 16'd0;
      assign sh_i   = in_val;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sh_i   = sh_r[k-1];
      assign side_i = side_r[k-1];
    end

    // trial subtract of the next bit pair
    always_comb begin
      tmp   = {rem_i, sh_i[31:30]};
      trial = {2'b00, root_i, 2'b01};
      if (tmp >= trial) begin
        rem_n  = 18'(tmp - trial);
        root_n = {root_i[14:0], 1'b1};
      end else begin
        rem_n  = tmp[17:0];
        root_n = {root_i[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
      if (en) begin
        rem_r[k]  <= rem_n;
        root_r[k] <= root_n;
        sh_r[k]   <= {sh_i[29:0], 2'b00};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_root  = root_r[Steps-1];
  assign out_side  = side_r[Steps-1];

endmodule

// ===== rtl/core/psgp_div.sv =====
// eight-stage restoring divider for an eight-bit quotient, one bit per stage
module psgp_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [23:0]       in_num,
  input  logic [15:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [7:0]        out_quot,
  output logic [SIDE_W-1:0] out_side
);
  localparam int unsigned Steps = 8;

  logic              v_r    [Steps];
  logic [15:0]       rem_r  [Steps];
  logic [7:0]        lo_r   [Steps];
  logic [7:0]        q_r    [Steps];
  logic [15:0]       den_r  [Steps];
  logic [SIDE_W-1:0] side_r [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic              v_i;
    logic [15:0]       rem_i;
    logic [7:0]        lo_i;
    logic [7:0]        q_i;
    logic [15:0]       den_i;
    logic [SIDE_W-1:0] side_i;
    logic [16:0]       t;
    logic [15:0]       rem_n;
    logic [7:0]        q_n;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_num[23:8];
      assign lo_i   = in_num[7:0];
      assign q_i    = 8'd0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign lo_i   = lo_r[k-1];
      assign q_i    = q_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    // shift in one numerator bit and try the subtract
    always_comb begin
      t = {rem_i, lo_i[7]};
      if (t >= {1'b0, den_i}) begin
        rem_n = 16'(t - {1'b0, den_i});
        q_n   = {q_i[6:0], 1'b1};
      end else begin
        rem_n = t[15:0];
        q_n   = {q_i[6:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
      if (en) begin
        rem_r[k]  <= rem_n;
        lo_r[k]   <= {lo_i[6:0], 1'b0};
        q_r[k]    <= q_n;
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_quot  = q_r[Steps-1];
  assign out_side  = side_r[Steps-1];

endmodule

// ===== rtl/core/positional_sound_gain_pan.sv =====
// Positional sound gain and pan: one result word per request word, fully pipelined. A request
// passes 3 front stages (channel lookup, squares, range test), 16 square-root stages, one
// multiply stage, an 8-stage divider for far-side falloff, one multiply stage, two parallel
// 8-stage dividers for distance falloff and the output register, and a new request is taken
// every cycle the output is not stalled. A stall at the result side holds the whole pipeline.
// Register writes must only happen while no request is in flight.
module positional_sound_gain_pan #(
  parameter int unsigned CHANNEL_COUNT = psgp_pkg::ChannelCountDefault,
  parameter int unsigned COORD_BITS    = psgp_pkg::CoordBitsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  psgp_in_if.sink    in_if,
  psgp_out_if.source out_if,
  psgp_cfg_if.sink   cfg_if
);

  // configuration registers
  logic [63:0]                  vol_low_r, vol_high_r;
  logic [15:0]                  pan_en_r;
  logic signed [COORD_BITS-1:0] lis_x_r, lis_y_r;
  logic [15:0]                  radius_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_low_r  <= psgp_pkg::VolLowReset;
      vol_high_r <= 64'd0;
      pan_en_r   <= 16'd0;
      lis_x_r    <= '0;
      lis_y_r    <= '0;
      radius_r   <= psgp_pkg::RadiusReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        psgp_pkg::REG_VOL_LOW:    vol_low_r  <= cfg_if.data;
        psgp_pkg::REG_VOL_HIGH:   vol_high_r <= cfg_if.data;
        psgp_pkg::REG_PAN_ENABLE: pan_en_r   <= cfg_if.data[15:0];
        psgp_pkg::REG_LISTENER_X: lis_x_r    <= cfg_if.data[COORD_BITS-1:0];
        psgp_pkg::REG_LISTENER_Y: lis_y_r    <= cfg_if.data[COORD_BITS-1:0];
        psgp_pkg::REG_RADIUS:     radius_r   <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being drained
  logic out_valid_r;
  logic en;
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // front stages
  logic            f_valid;
  logic [31:0]     f_sq;
  psgp_pkg::side_t f_side;

  psgp_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_if.valid),
    .channel_index(in_if.channel_index),
    .sample_index (in_if.sample_index),
    .positional   (in_if.positional),
    .no_panning   (in_if.no_panning),
    .source_x     (in_if.source_x),
    .source_y     (in_if.source_y),
    .vol_all      ({vol_high_r, vol_low_r}),
    .pan_enable   (pan_en_r),
    .listener_x   (lis_x_r),
    .listener_y   (lis_y_r),
    .radius       (radius_r),
    .out_valid    (f_valid),
    .out_sq       (f_sq),
    .out_side     (f_side)
  );

  // distance
  logic                    q_valid;
  logic [15:0]             q_root;
  logic [$bits(psgp_pkg::side_t)-1:0] q_side_bits;
  psgp_pkg::side_t         q_side;

  psgp_sqrt #(.SIDE_W($bits(psgp_pkg::side_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_val   (f_sq),
    .in_side  (f_side),
    .out_valid(q_valid),
    .out_root (q_root),
    .out_side (q_side_bits)
  );
  assign q_side = psgp_pkg::side_t'(q_side_bits);

  // far-side numerator
  logic           m1_valid_r;
  logic [23:0]    m1_num_r;
  psgp_pkg::mid_t m1_mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= q_valid;
    end
    if (en) begin
      m1_num_r          <= 24'(16'(q_side.radius - q_side.ax)) * 24'(q_side.vol);
      m1_mid_r.side     <= q_side;
      m1_mid_r.distance <= q_root;
    end
  end

  logic                                d1_valid;
  logic [7:0]                          d1_quot;
  logic [$bits(psgp_pkg::mid_t)-1:0]   d1_mid_bits;
  psgp_pkg::mid_t                      d1_mid;

  psgp_div #(.SIDE_W($bits(psgp_pkg::mid_t))) u_div_far (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m1_valid_r),
    .in_num   (m1_num_r),
    .in_den   (m1_mid_r.side.radius),
    .in_side  (m1_mid_r),
    .out_valid(d1_valid),
    .out_quot (d1_quot),
    .out_side (d1_mid_bits)
  );
  assign d1_mid = psgp_pkg::mid_t'(d1_mid_bits);

  // panned sides times remaining distance
  logic            m2_valid_r;
  logic [23:0]     m2_nl_r, m2_nr_r;
  logic [15:0]     m2_den_r;
  logic            m2_aud_r;
  psgp_pkg::tail_t m2_tail_r;
  logic [7:0]      lv_p, rv_p;
  logic [15:0]     rem_dist;

  always_comb begin
    lv_p = d1_mid.side.vol;
    rv_p = d1_mid.side.vol;
    if (!d1_mid.side.no_pan) begin
      if (d1_mid.side.dx_pos) begin
        lv_p = d1_quot;
      end else begin
        rv_p = d1_quot;
      end
    end
    rem_dist = 16'(d1_mid.side.radius - d1_mid.distance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m2_valid_r <= d1_valid;
    end
    if (en) begin
      m2_nl_r          <= 24'(lv_p) * 24'(rem_dist);
      m2_nr_r          <= 24'(rv_p) * 24'(rem_dist);
      m2_den_r         <= d1_mid.side.radius;
      m2_aud_r         <= d1_mid.side.audible;
      m2_tail_r.sample <= d1_mid.side.sample;
      m2_tail_r.vol    <= d1_mid.side.vol;
      m2_tail_r.active <= d1_mid.side.active;
    end
  end

  // distance falloff, both sides in lockstep
  logic                               dl_valid, dr_valid;
  logic [7:0]                         dl_quot, dr_quot;
  logic [$bits(psgp_pkg::tail_t)-1:0] dl_tail_bits;
  psgp_pkg::tail_t                    dl_tail;
  logic                               dr_aud;

  psgp_div #(.SIDE_W($bits(psgp_pkg::tail_t))) u_div_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m2_valid_r),
    .in_num   (m2_nl_r),
    .in_den   (m2_den_r),
    .in_side  (m2_tail_r),
    .out_valid(dl_valid),
    .out_quot (dl_quot),
    .out_side (dl_tail_bits)
  );
  assign dl_tail = psgp_pkg::tail_t'(dl_tail_bits);

  psgp_div #(.SIDE_W(1)) u_div_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m2_valid_r),
    .in_num   (m2_nr_r),
    .in_den   (m2_den_r),
    .in_side  (m2_aud_r),
    .out_valid(dr_valid),
    .out_quot (dr_quot),
    .out_side (dr_aud)
  );

  // final volume and pan
  logic [7:0]        lf, rf;
  logic [8:0]        sum_lr;
  logic [15:0]       vol_y, pan_y;
  logic signed [8:0] diff;
  logic [7:0]        mag;
  logic [7:0]        volp, panm;
  logic              nz;
  logic              start_r;
  logic [8:0]        sample_r;
  logic [6:0]        volp_r;
  logic signed [7:0] panp_r;

  always_comb begin
    if (dl_tail.active) begin
      lf = dr_aud ? dl_quot : 8'd0;
      rf = dr_aud ? dr_quot : 8'd0;
    end else begin
      lf = dl_tail.vol;
      rf = dl_tail.vol;
    end
    nz     = (lf != 8'd0) || (rf != 8'd0);
    sum_lr = {1'b0, lf} + {1'b0, rf};
    vol_y  = 16'(sum_lr[8:1]) * 16'd100;
    volp   = psgp_pkg::div255(vol_y);
    diff   = $signed({1'b0, rf}) - $signed({1'b0, lf});
    mag    = diff[8] ? 8'(-diff) : diff[7:0];
    pan_y  = 16'(mag) * 16'd100;
    panm   = psgp_pkg::div255(pan_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dl_valid && dr_valid;
    end
    if (en) begin
      start_r  <= nz;
      sample_r <= dl_tail.sample;
      volp_r   <= nz ? volp[6:0] : 7'd0;
      panp_r   <= !nz ? 8'sd0 : (diff[8] ? $signed(8'(-panm)) : $signed(panm));
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.start_playback = start_r;
  assign out_if.sample_out     = sample_r;
  assign out_if.volume_percent = volp_r;
  assign out_if.pan_percent    = panp_r;

endmodule
